>>> sv/sst_pkg.sv
// ----------------------------------------------------------------------------
// Spindle speed settle tracker package
// Shared types and constants for the tracker core and its step logic.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam logic [15:0] MaxStartMargin = 16'd1000;
  localparam logic [9:0]  TolReset       = 10'd20;

  typedef enum logic [1:0] {
    OpStart  = 2'd0,
    OpChange = 2'd1,
    OpStop   = 2'd2,
    OpTick   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ModeStopped  = 2'd0,
    ModeChanging = 2'd1,
    ModeAtSpeed  = 2'd2,
    ModeStopping = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] requested_speed;
    logic [15:0] measured_speed;
    logic        spinning;
  } in_item_t;

  typedef struct packed {
    logic [1:0] disk_mode;
    logic       speed_error;
    logic       settled;
  } out_item_t;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] target_speed;
    logic [15:0] last_speed;
    logic [15:0] lowest_extreme;
    logic [16:0] highest_extreme;
    logic        direction_unknown;
    logic        rising;
    logic        unchanged_once;
  } trk_state_t;

endpackage

>>> sv/sst_step.sv
// ----------------------------------------------------------------------------
// Spindle speed settle tracker step logic
// Computes the next tracker state and the result for one request.
// ----------------------------------------------------------------------------
module sst_step import sst_pkg::*; (
  input  trk_state_t state_i,
  input  in_item_t   item_i,
  input  logic [9:0] tol_i,
  output trk_state_t state_o,
  output out_item_t  result_o
);

  trk_state_t  s;
  logic        err;
  logic        settled;
  logic        enter;
  logic        up;
  logic [15:0] cur;
  logic [15:0] prev;
  logic [15:0] tgt;
  logic [15:0] tol_ext;
  logic [15:0] lo_edge;
  logic [16:0] hi_edge;
  op_e         op;

  assign op      = op_e'(item_i.operation);
  assign cur     = item_i.measured_speed;
  assign prev    = state_i.last_speed;
  assign tgt     = state_i.target_speed;
  assign up      = cur > prev;
  assign tol_ext = {6'd0, tol_i};
  assign lo_edge = (tgt > tol_ext) ? (tgt - tol_ext) : 16'd0;
  assign hi_edge = {1'b0, tgt} + {7'd0, tol_i};

  always_comb begin
    s       = state_i;
    err     = 1'b0;
    settled = 1'b0;
    enter   = 1'b0;
    unique case (op)
      OpStart: begin
        enter = (state_i.mode == ModeStopped) || (state_i.mode == ModeStopping);
      end
      OpChange: begin
        enter = (state_i.mode == ModeChanging) || (state_i.mode == ModeAtSpeed);
      end
      OpStop: begin
        if ((state_i.mode == ModeChanging) || (state_i.mode == ModeAtSpeed)) begin
          s.mode = ModeStopping;
        end
      end
      OpTick: begin
        if (state_i.mode == ModeChanging) begin
          s.last_speed = cur;
          if (cur != prev) begin
            s.unchanged_once = 1'b0;
            if (state_i.direction_unknown) begin
              s.direction_unknown = 1'b0;
            end else if (up && !state_i.rising) begin
              if ((cur <= tgt) || (prev < tgt)) begin
                s.lowest_extreme = prev;
              end
            end else if (!up && state_i.rising) begin
              if ((cur >= tgt) || (prev > tgt)) begin
                s.highest_extreme = {1'b0, prev};
              end
            end
            s.rising = up;
          end else begin
            if (state_i.unchanged_once) begin
              if (cur == tgt) begin
                s.lowest_extreme  = tgt;
                s.highest_extreme = {1'b0, tgt};
              end else begin
                err = 1'b1;
              end
            end
            s.unchanged_once = 1'b1;
          end
          if ((s.lowest_extreme >= lo_edge) && (s.highest_extreme <= hi_edge)) begin
            s.mode  = ModeAtSpeed;
            settled = 1'b1;
          end
        end else if (state_i.mode == ModeStopping) begin
          if (!item_i.spinning) begin
            s.mode = ModeStopped;
          end
        end
      end
      default: begin
        s = state_i;
      end
    endcase
    if (enter) begin
      s.mode              = ModeChanging;
      s.target_speed      = item_i.requested_speed;
      s.last_speed        = item_i.measured_speed;
      s.direction_unknown = 1'b1;
      s.lowest_extreme    = 16'd0;
      s.highest_extreme   = {1'b0, item_i.requested_speed} + {1'b0, MaxStartMargin};
      s.unchanged_once    = 1'b0;
    end
  end

  assign state_o              = s;
  assign result_o.disk_mode   = s.mode;
  assign result_o.speed_error = err;
  assign result_o.settled     = settled;

endmodule

>>> sv/spindle_speed_settle_tracker_core.sv
// ----------------------------------------------------------------------------
// Spindle speed settle tracker core
// Follows a disk through stopped, changing, at speed and stopping modes.
// ----------------------------------------------------------------------------
// Each request passes through an input register and is resolved combinationally
// against the tracker state, landing in a result register; one request is taken
// every cycle while results are drained. The rate is set by the state update of
// the step logic, whose result feeds straight back into the tracker state register.
module spindle_speed_settle_tracker_core import sst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [9:0] cfg_data_i
);

  logic       in_valid_q;
  in_item_t   in_item_q;
  logic       out_valid_q;
  out_item_t  out_item_q;
  logic [9:0] tol_q;
  trk_state_t state_q;
  trk_state_t state_d;
  out_item_t  result_d;
  logic       advance;
  logic       fire;

  assign advance     = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && advance;
  assign in_stall_o  = in_valid_q && !advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  sst_step u_step (
    .state_i  (state_q),
    .item_i   (in_item_q),
    .tol_i    (tol_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode              <= ModeStopped;
      state_q.target_speed      <= 16'd0;
      state_q.last_speed        <= 16'd0;
      state_q.lowest_extreme    <= 16'd0;
      state_q.highest_extreme   <= 17'd0;
      state_q.direction_unknown <= 1'b1;
      state_q.rising            <= 1'b1;
      state_q.unchanged_once    <= 1'b0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  a_settled_at_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.settled) |-> (out_data_o.disk_mode == ModeAtSpeed))
    else $error("settled result without at-speed mode");

  a_error_while_changing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.speed_error) |->
      ((out_data_o.disk_mode == ModeChanging) || (out_data_o.disk_mode == ModeAtSpeed)))
    else $error("speed error reported outside changing mode");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled without a pending request");

  a_result_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (out_valid_o && (out_data_o.disk_mode == state_q.mode)))
    else $error("result mode differs from tracker state");

endmodule

>>> tb/sv/spindle_speed_settle_tracker_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spindle speed settle tracker core testbench
// Drives start, change-speed, stop and polling-tick requests into the core
// while an independent model of the tracker predicts mode, error and settle
// flags for every accepted request. Results are compared in order against
// the model. The run covers a directed sequence, then damped speed profiles
// with random content and random noise under several tolerance settings,
// with random gaps on the input channel and random stalls on the output channel.
// ----------------------------------------------------------------------------
module spindle_speed_settle_tracker_core_tb;
  import sst_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int PhaseRequests = 150;

  class settle_scoreboard;
    mode_e       mode;
    logic [15:0] target_spd;
    logic [15:0] last_spd;
    logic [15:0] low_ext;
    logic [16:0] high_ext;
    bit          dir_unknown;
    bit          rising;
    bit          unchanged_once;
    logic [9:0]  tolerance;
    out_item_t   expected_status_q[$];
    int          mismatches;

    function new();
      mode           = ModeStopped;
      target_spd     = '0;
      last_spd       = '0;
      low_ext        = '0;
      high_ext       = '0;
      dir_unknown    = 1'b1;
      rising         = 1'b1;
      unchanged_once = 1'b0;
      tolerance      = TolReset;
      mismatches     = 0;
    endfunction

    function void enter_changing(logic [15:0] req, logic [15:0] meas);
      mode           = ModeChanging;
      target_spd     = req;
      last_spd       = meas;
      dir_unknown    = 1'b1;
      low_ext        = '0;
      high_ext       = {1'b0, req} + {1'b0, MaxStartMargin};
      unchanged_once = 1'b0;
    endfunction

    function bit track_tick(logic [15:0] cur, output bit err);
      logic [15:0] prev;
      logic [15:0] lo_edge;
      logic [16:0] hi_edge;
      bit          up;
      err = 1'b0;
      prev = last_spd;
      last_spd = cur;
      if (cur != prev) begin
        up = cur > prev;
        unchanged_once = 1'b0;
        if (dir_unknown) begin
          dir_unknown = 1'b0;
        end else if (up && !rising) begin
          if (cur <= target_spd || prev < target_spd) low_ext = prev;
        end else if (!up && rising) begin
          if (cur >= target_spd || prev > target_spd) high_ext = {1'b0, prev};
        end
        rising = up;
      end else begin
        if (unchanged_once) begin
          if (cur == target_spd) begin
            low_ext  = target_spd;
            high_ext = {1'b0, target_spd};
          end else begin
            err = 1'b1;
          end
        end
        unchanged_once = 1'b1;
      end
      lo_edge = (target_spd > {6'd0, tolerance}) ? target_spd - {6'd0, tolerance} : 16'd0;
      hi_edge = {1'b0, target_spd} + {7'd0, tolerance};
      return (low_ext >= lo_edge) && (high_ext <= hi_edge);
    endfunction

    function out_item_t predict_step(in_item_t req);
      out_item_t res;
      bit        err;
      bit        done;
      err  = 1'b0;
      done = 1'b0;
      case (req.operation)
        OpStart: begin
          if (mode == ModeStopped || mode == ModeStopping)
            enter_changing(req.requested_speed, req.measured_speed);
        end
        OpChange: begin
          if (mode == ModeChanging || mode == ModeAtSpeed)
            enter_changing(req.requested_speed, req.measured_speed);
        end
        OpStop: begin
          if (mode == ModeChanging || mode == ModeAtSpeed) mode = ModeStopping;
        end
        default: begin
          if (mode == ModeChanging) begin
            if (track_tick(req.measured_speed, err)) begin
              mode = ModeAtSpeed;
              done = 1'b1;
            end
          end else if (mode == ModeStopping && !req.spinning) begin
            mode = ModeStopped;
          end
        end
      endcase
      res.disk_mode   = mode;
      res.speed_error = err;
      res.settled     = done;
      return res;
    endfunction

    function void note_request(in_item_t req);
      expected_status_q.push_back(predict_step(req));
    endfunction

    function int pending();
      return expected_status_q.size();
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_status_q.size() == 0) begin
        report_mismatch("unexpected result, mode", got.disk_mode, -1);
      end else begin
        want = expected_status_q.pop_front();
        if (got.disk_mode != want.disk_mode)
          report_mismatch("disk_mode", got.disk_mode, want.disk_mode);
        if (got.speed_error != want.speed_error)
          report_mismatch("speed_error", got.speed_error, want.speed_error);
        if (got.settled != want.settled)
          report_mismatch("settled", got.settled, want.settled);
      end
    endtask
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_item_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [9:0] cfg_data_i  = '0;

  settle_scoreboard sb = new();
  int idle_cycles = 0;
  int stall_run   = 0;
  int items_sent  = 0;
  bit calm        = 1'b0;

  spindle_speed_settle_tracker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int burst_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 1;
    if (r < 90) return $urandom_range(2, 4);
    if (r < 98) return $urandom_range(5, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic int clamp_speed(int v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  function automatic int pick_speed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, 40);
    if (r < 30) return $urandom_range(65480, 65535);
    return $urandom_range(0, 65535);
  endfunction

  always @(posedge clk_i) begin
    if (calm) begin
      out_stall_i <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else if ($urandom_range(0, 1) == 0) begin
      out_stall_i <= 1'b0;
      stall_run = $urandom_range(0, 15);
    end else begin
      out_stall_i <= 1'b1;
      stall_run = burst_length() - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_request(input in_item_t req);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : burst_length();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic issue(input op_e op, input int req_spd, input int meas_spd, input bit spin);
    in_item_t req;
    req.operation       = op;
    req.requested_speed = req_spd[15:0];
    req.measured_speed  = meas_spd[15:0];
    req.spinning        = spin;
    send_request(req);
  endtask

  task automatic tick(input int meas_spd);
    issue(OpTick, $urandom_range(0, 65535), meas_spd, 1'($urandom_range(0, 1)));
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input logic [9:0] tol);
    drain_requests();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= tol;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.tolerance = tol;
  endtask

  task automatic run_profiles(input int count);
    int goal;
    int target;
    int meas;
    int amp;
    int n;
    goal = items_sent + count;
    while (items_sent < goal) begin
      calm = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 99) < 78) begin
        target = pick_speed();
        meas = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535) :
               clamp_speed(target + $urandom_range(0, 6000) - 3000);
        if ($urandom_range(0, 3) != 0) issue(OpStart, target, meas, 1'($urandom_range(0, 1)));
        issue(OpChange, target, meas, 1'($urandom_range(0, 1)));
        amp = meas - target;
        n = $urandom_range(3, 16);
        repeat (n) begin
          if ($urandom_range(0, 4) != 0) begin
            amp = -(amp * int'($urandom_range(20, 80))) / 100;
            if ($urandom_range(0, 5) == 0) amp = amp + int'($urandom_range(0, 6)) - 3;
            meas = clamp_speed(target + amp);
          end
          tick(meas);
        end
        if ($urandom_range(0, 6) == 0) begin
          meas = ($urandom_range(0, 1) == 0) ? target :
                 clamp_speed(target + $urandom_range(0, 400) - 200);
          repeat ($urandom_range(2, 4)) tick(meas);
        end
        if ($urandom_range(0, 99) < 35) begin
          issue(OpStop, $urandom_range(0, 65535), $urandom_range(0, 65535),
                1'($urandom_range(0, 1)));
          repeat ($urandom_range(0, 3)) issue(OpTick, $urandom_range(0, 65535),
                                              $urandom_range(0, 65535), 1'b1);
          issue(OpTick, $urandom_range(0, 65535), $urandom_range(0, 65535), 1'b0);
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          issue(op_e'($urandom_range(0, 3)), $urandom_range(0, 65535),
                $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    logic [9:0] tol_plan [5];
    tol_plan[0] = 10'd0;
    tol_plan[1] = 10'd1023;
    tol_plan[2] = 10'($urandom_range(0, 1023));
    tol_plan[3] = 10'd1;
    tol_plan[4] = 10'($urandom_range(2, 60));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    issue(OpTick,   16'hFFFF, 16'hFFFF, 1'b1);
    issue(OpStop,   0, 0, 1'b0);
    issue(OpChange, 300, 300, 1'b0);
    issue(OpStart,  0, 0, 1'b0);
    issue(OpTick,   0, 0, 1'b0);
    issue(OpTick,   0, 0, 1'b0);
    issue(OpStart,  700, 700, 1'b1);
    issue(OpTick,   0, 1234, 1'b0);
    issue(OpChange, 16'hFFFF, 0, 1'b1);
    issue(OpTick,   0, 16'hFFFF, 1'b1);
    issue(OpTick,   0, 16'hFFFF, 1'b0);
    issue(OpTick,   0, 16'hFFFF, 1'b1);
    issue(OpChange, 1000, 0, 1'b0);
    issue(OpTick,   0, 1200, 1'b0);
    issue(OpTick,   0, 900, 1'b0);
    issue(OpTick,   0, 1010, 1'b0);
    issue(OpTick,   0, 995, 1'b0);
    issue(OpTick,   0, 1005, 1'b0);
    issue(OpChange, 500, 700, 1'b0);
    issue(OpTick,   0, 600, 1'b0);
    issue(OpTick,   0, 600, 1'b0);
    issue(OpTick,   0, 600, 1'b0);
    issue(OpTick,   0, 600, 1'b0);
    issue(OpStop,   0, 0, 1'b0);
    issue(OpTick,   0, 0, 1'b1);
    issue(OpStart,  5, 40, 1'b0);
    issue(OpStop,   0, 0, 1'b1);
    issue(OpTick,   0, 0, 1'b0);

    foreach (tol_plan[i]) begin
      write_tolerance(tol_plan[i]);
      run_profiles(PhaseRequests);
    end

    drain_requests();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
